>>> hw/rtl/dpp_pkg.sv
// Shared types, constants and ring index helpers for the delta pattern prefetcher.
// Used by every module of the block; depends on nothing.
package dpp_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int RING_DEPTH    = 16;
  localparam int BLOCK_BYTES   = 64;
  localparam int ADDR_BITS     = 32;
  localparam int MAX_RESULTS   = 16;

  localparam int PC_BITS    = 32;
  localparam int IN_ADDR_BITS = 32;
  localparam int PFA_BITS   = 32;
  localparam int LIMIT_BITS = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;

  localparam int ADDR_EFF   = (ADDR_BITS < IN_ADDR_BITS) ? ADDR_BITS : IN_ADDR_BITS;
  localparam int OFF_BITS   = $clog2(BLOCK_BYTES);
  localparam int BLK_BITS   = ADDR_EFF - OFF_BITS;
  localparam int DELTA_BITS = BLK_BITS + 1;
  localparam int CAND_BITS  = BLK_BITS + 2;
  localparam int IDX_BITS   = $clog2(TABLE_ENTRIES);
  localparam int POS_BITS   = $clog2(RING_DEPTH);
  localparam int FILL_BITS  = $clog2(RING_DEPTH + 1);
  localparam int CNT_BITS   = $clog2(MAX_RESULTS + 1);
  localparam int RA_BITS    = $clog2(TABLE_ENTRIES * RING_DEPTH);
  localparam int CMP_BITS   = (CAND_BITS + OFF_BITS > LIMIT_BITS) ?
                              CAND_BITS + OFF_BITS : LIMIT_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MEM_LIMIT = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUP_FILT  = CFG_IDX_BITS'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCHK, S_ALLOC, S_HIT, S_SRCH_RD, S_SRCH_CMP, S_REPLAY,
    S_FLT_RD, S_FLT_ACC, S_EMT_RD, S_EMT_ACC, S_EMT_PUSH, S_FLUSH, S_FIN
  } state_t;

  typedef struct packed {
    logic [PC_BITS-1:0]          pc;
    logic [BLK_BITS-1:0]         last_block;
    logic signed [CAND_BITS-1:0] last_prefetch;
    logic [POS_BITS-1:0]         head;
    logic [FILL_BITS-1:0]        fill;
  } entry_t;

  typedef struct packed {
    logic                we_all;
    logic                we_lp;
    logic [IDX_BITS-1:0] idx;
    entry_t              data;
  } tbl_wr_t;

  typedef struct packed {
    logic                  en;
    logic [RA_BITS-1:0]    addr;
    logic [DELTA_BITS-1:0] data;
  } ring_wr_t;

  typedef struct packed {
    logic [RA_BITS-1:0] addr_a;
    logic [RA_BITS-1:0] addr_b;
  } ring_rd_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] memory_limit;
    logic                  dup_filter_en;
  } cfg_t;

  function automatic logic [POS_BITS-1:0] pos_inc(input logic [POS_BITS-1:0] x);
    logic [POS_BITS-1:0] y;
    if (x == POS_BITS'(RING_DEPTH - 1)) y = '0;
    else y = x + POS_BITS'(1);
    return y;
  endfunction

  // Position n steps behind h, with n at most RING_DEPTH.
  function automatic logic [POS_BITS-1:0] pos_sub(input logic [POS_BITS-1:0] h,
                                                  input logic [FILL_BITS-1:0] n);
    logic [POS_BITS+1:0] s;
    s = (POS_BITS+2)'(h) + (POS_BITS+2)'(RING_DEPTH) - (POS_BITS+2)'(n);
    if (s >= (POS_BITS+2)'(RING_DEPTH)) s = s - (POS_BITS+2)'(RING_DEPTH);
    return s[POS_BITS-1:0];
  endfunction

  function automatic logic [RA_BITS-1:0] ring_addr(input logic [IDX_BITS-1:0] idx,
                                                   input logic [POS_BITS-1:0] pos);
    return RA_BITS'(idx) * RA_BITS'(RING_DEPTH) + RA_BITS'(pos);
  endfunction

endpackage

>>> hw/rtl/delta_pattern_prefetcher.sv
// Delta pattern prefetcher top level: config registers, table, ring and sequencer.
// An access scans the table entries (up to 128), then runs pattern compares (up to 92
// at full fill), replay passes over the deltas and the output of each emitted word;
// output stalls can hold it. It takes one access at a time; in_ready is high only
// between accesses. Reset is synchronous; the valid bits clear at once.
// Depends on dpp_pkg, dpp_table, dpp_ring and dpp_ctrl.
module delta_pattern_prefetcher (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dpp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [dpp_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpp_pkg::PC_BITS-1:0]         in_access_pc,
  input  logic [dpp_pkg::IN_ADDR_BITS-1:0]    in_access_addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dpp_pkg::PFA_BITS-1:0]        out_prefetch_addr,
  output logic                                out_last_of_run
);
  import dpp_pkg::*;

  cfg_t                  cfg_r;
  logic [IDX_BITS-1:0]   tbl_rd_idx;
  logic                  tbl_rd_valid;
  entry_t                tbl_rd_entry;
  tbl_wr_t               tbl_wr;
  ring_rd_t              ring_rd;
  ring_wr_t              ring_wr;
  logic [DELTA_BITS-1:0] ring_da, ring_db;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.memory_limit  <= '1;
      cfg_r.dup_filter_en <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MEM_LIMIT: cfg_r.memory_limit  <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_DUP_FILT:  cfg_r.dup_filter_en <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dpp_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (tbl_rd_idx),
    .rd_valid (tbl_rd_valid),
    .rd_entry (tbl_rd_entry),
    .wr       (tbl_wr)
  );

  dpp_ring u_ring (
    .clk  (clk),
    .wr   (ring_wr),
    .rd   (ring_rd),
    .rd_a (ring_da),
    .rd_b (ring_db)
  );

  dpp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pc        (in_access_pc),
    .in_addr      (in_access_addr),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_addr     (out_prefetch_addr),
    .out_last     (out_last_of_run),
    .tbl_rd_idx   (tbl_rd_idx),
    .tbl_rd_valid (tbl_rd_valid),
    .tbl_rd_entry (tbl_rd_entry),
    .tbl_wr       (tbl_wr),
    .ring_rd      (ring_rd),
    .ring_wr      (ring_wr),
    .ring_da      (ring_da),
    .ring_db      (ring_db)
  );

  // An accepted access keeps the block busy for at least the scan.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second access in the next cycle");

  // A delta is pushed only together with the hit update of its entry.
  a_ring_with_table: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr.en |-> tbl_wr.we_all && !tbl_wr.we_lp)
    else $error("ring write without table update");

  // A new result word only appears while an access is being worked on.
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result word produced while idle");

endmodule

>>> hw/rtl/dpp_table.sv
// Prediction table: per-entry valid bits in flip-flops and entry fields in memories.
// Depends on dpp_pkg.
module dpp_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dpp_pkg::IDX_BITS-1:0] rd_idx,
  output logic                        rd_valid,
  output dpp_pkg::entry_t             rd_entry,
  input  dpp_pkg::tbl_wr_t            wr
);
  import dpp_pkg::*;

  typedef struct packed {
    logic [PC_BITS-1:0]   pc;
    logic [BLK_BITS-1:0]  last_block;
    logic [POS_BITS-1:0]  head;
    logic [FILL_BITS-1:0] fill;
  } main_t;

  main_t                       main_mem [TABLE_ENTRIES];
  logic signed [CAND_BITS-1:0] lp_mem   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    valid_r;
  main_t                       main_rd_r;
  logic signed [CAND_BITS-1:0] lp_rd_r;
  logic                        rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.we_all) valid_r[wr.idx] <= 1'b1;
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_all) begin
      main_mem[wr.idx] <= '{pc: wr.data.pc, last_block: wr.data.last_block,
                            head: wr.data.head, fill: wr.data.fill};
    end
    if (wr.we_all || wr.we_lp) lp_mem[wr.idx] <= wr.data.last_prefetch;
    main_rd_r <= main_mem[rd_idx];
    lp_rd_r   <= lp_mem[rd_idx];
  end

  assign rd_valid = rd_valid_r;
  assign rd_entry = '{pc: main_rd_r.pc, last_block: main_rd_r.last_block,
                      last_prefetch: lp_rd_r, head: main_rd_r.head, fill: main_rd_r.fill};

endmodule

>>> hw/rtl/dpp_ring.sv
// Delta ring store for all entries: one write port, two registered read ports.
// Depends on dpp_pkg.
module dpp_ring (
  input  logic                           clk,
  input  dpp_pkg::ring_wr_t              wr,
  input  dpp_pkg::ring_rd_t              rd,
  output logic [dpp_pkg::DELTA_BITS-1:0] rd_a,
  output logic [dpp_pkg::DELTA_BITS-1:0] rd_b
);
  import dpp_pkg::*;

  logic [DELTA_BITS-1:0] mem [TABLE_ENTRIES*RING_DEPTH];
  logic [DELTA_BITS-1:0] rd_a_r;
  logic [DELTA_BITS-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
    rd_a_r <= mem[rd.addr_a];
    rd_b_r <= mem[rd.addr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

>>> hw/rtl/dpp_ctrl.sv
// Sequencer and shared adder/comparator: table scan, pattern search, replay and output.
// Depends on dpp_pkg; drives dpp_table and dpp_ring.
module dpp_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dpp_pkg::cfg_t                    cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dpp_pkg::PC_BITS-1:0]      in_pc,
  input  logic [dpp_pkg::IN_ADDR_BITS-1:0] in_addr,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dpp_pkg::PFA_BITS-1:0]     out_addr,
  output logic                             out_last,
  output logic [dpp_pkg::IDX_BITS-1:0]     tbl_rd_idx,
  input  logic                             tbl_rd_valid,
  input  dpp_pkg::entry_t                  tbl_rd_entry,
  output dpp_pkg::tbl_wr_t                 tbl_wr,
  output dpp_pkg::ring_rd_t                ring_rd,
  output dpp_pkg::ring_wr_t                ring_wr,
  input  logic [dpp_pkg::DELTA_BITS-1:0]   ring_da,
  input  logic [dpp_pkg::DELTA_BITS-1:0]   ring_db
);
  import dpp_pkg::*;

  state_t state_r, state_nxt;

  logic [PC_BITS-1:0]          pc_r;
  logic [BLK_BITS-1:0]         block_r;
  logic [IDX_BITS-1:0]         scan_r, eidx_r, rp_r;
  entry_t                      ent_r;
  logic [POS_BITS-1:0]         head_r, patpos_r, qpos_r, fpos_r, start_r, t_r;
  logic [FILL_BITS-1:0]        fill_r, p_r, i_r, j_r;
  logic                        found_r, drop_r;
  logic signed [CAND_BITS-1:0] prev_r;
  logic [CNT_BITS-1:0]         n_r;
  logic                        pend_v_r, out_v_r, out_last_r;
  logic [PFA_BITS-1:0]         pend_addr_r, cand_addr_r, out_addr_r;

  logic                        hit, out_free, srch_more, p_more, t_last, cand_ok, push_move;
  logic [POS_BITS-1:0]         new_head, t_inc;
  logic [FILL_BITS-1:0]        new_fill, i_inc;
  logic signed [CAND_BITS-1:0] add_a, add_b, add_y, cmp_a, cmp_b, blk_ext;
  logic                        add_sub, cmp_eq;
  logic [CAND_BITS+OFF_BITS-1:0] cand_bytes;

  assign hit      = tbl_rd_valid && (tbl_rd_entry.pc == pc_r);
  assign out_free = !out_v_r || out_ready;
  assign new_head = pos_inc(ent_r.head);
  assign new_fill = (ent_r.fill < FILL_BITS'(RING_DEPTH)) ? ent_r.fill + FILL_BITS'(1)
                                                           : ent_r.fill;
  assign i_inc    = i_r + FILL_BITS'(1);
  assign srch_more = ((FILL_BITS+1)'(i_inc) + (FILL_BITS+1)'(p_r)) < (FILL_BITS+1)'(fill_r);
  assign p_more   = (p_r + FILL_BITS'(1)) <= (fill_r >> 1);
  assign t_inc    = pos_inc(t_r);
  assign t_last   = (t_inc == head_r);
  assign blk_ext  = CAND_BITS'(block_r);
  assign push_move = !pend_v_r || out_free;

  // Shared adder: entry delta on a hit, running candidate during replay.
  always_comb begin
    add_a   = prev_r;
    add_b   = CAND_BITS'(signed'(ring_da));
    add_sub = 1'b0;
    if (state_r == S_HIT) begin
      add_a   = blk_ext;
      add_b   = CAND_BITS'(ent_r.last_block);
      add_sub = 1'b1;
    end
    add_y = add_sub ? add_a - add_b : add_a + add_b;
  end

  // Shared comparator: pattern match during the search, last prefetch during the filter.
  always_comb begin
    cmp_a = add_y;
    cmp_b = ent_r.last_prefetch;
    if (state_r == S_SRCH_CMP) begin
      cmp_a = CAND_BITS'(signed'(ring_da));
      cmp_b = CAND_BITS'(signed'(ring_db));
    end
    cmp_eq = (cmp_a == cmp_b);
  end

  assign cand_bytes = {add_y, {OFF_BITS{1'b0}}};
  assign cand_ok = (add_y > 0) && (CMP_BITS'(cand_bytes) < CMP_BITS'(cfg.memory_limit))
                   && (n_r < CNT_BITS'(MAX_RESULTS));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_SCAN;
      S_SCAN:     state_nxt = S_SCHK;
      S_SCHK: begin
        if (hit) state_nxt = S_HIT;
        else if (scan_r == IDX_BITS'(TABLE_ENTRIES - 1)) state_nxt = S_ALLOC;
        else state_nxt = S_SCAN;
      end
      S_ALLOC:    state_nxt = S_IDLE;
      S_HIT:      state_nxt = ((new_fill >> 1) != '0) ? S_SRCH_RD : S_REPLAY;
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = (srch_more || p_more) ? S_SRCH_RD : S_REPLAY;
      S_REPLAY: begin
        if (start_r == head_r) state_nxt = S_FIN;
        else if (cfg.dup_filter_en) state_nxt = S_FLT_RD;
        else state_nxt = S_EMT_RD;
      end
      S_FLT_RD:   state_nxt = S_FLT_ACC;
      S_FLT_ACC: begin
        if (!t_last) state_nxt = S_FLT_RD;
        else if (drop_r || cmp_eq) state_nxt = S_FIN;
        else state_nxt = S_EMT_RD;
      end
      S_EMT_RD:   state_nxt = S_EMT_ACC;
      S_EMT_ACC: begin
        if (cand_ok) state_nxt = S_EMT_PUSH;
        else if (t_last) state_nxt = S_FLUSH;
        else state_nxt = S_EMT_RD;
      end
      S_EMT_PUSH: if (push_move) state_nxt = (t_r == head_r) ? S_FLUSH : S_EMT_RD;
      S_FLUSH:    if (!pend_v_r || out_free) state_nxt = S_FIN;
      S_FIN:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state_r == S_IDLE);
    tbl_rd_idx = scan_r;
    tbl_wr     = '0;
    ring_wr    = '0;
    ring_rd.addr_a = ring_addr(eidx_r, (state_r == S_SRCH_RD) ? patpos_r : t_r);
    ring_rd.addr_b = ring_addr(eidx_r, qpos_r);
    unique case (state_r)
      S_ALLOC: begin
        tbl_wr.we_all = 1'b1;
        tbl_wr.idx    = rp_r;
        tbl_wr.data   = '{pc: pc_r, last_block: block_r, last_prefetch: '0,
                          head: '0, fill: '0};
      end
      S_HIT: begin
        tbl_wr.we_all = 1'b1;
        tbl_wr.idx    = eidx_r;
        tbl_wr.data   = '{pc: ent_r.pc, last_block: block_r,
                          last_prefetch: ent_r.last_prefetch, head: new_head, fill: new_fill};
        ring_wr.en    = 1'b1;
        ring_wr.addr  = ring_addr(eidx_r, ent_r.head);
        ring_wr.data  = add_y[DELTA_BITS-1:0];
      end
      S_FIN: begin
        tbl_wr.we_lp = 1'b1;
        tbl_wr.idx   = eidx_r;
        tbl_wr.data.last_prefetch = prev_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rp_r     <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ALLOC) begin
        rp_r <= (rp_r == IDX_BITS'(TABLE_ENTRIES - 1)) ? '0 : rp_r + IDX_BITS'(1);
      end
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (state_r == S_EMT_PUSH && push_move) begin
        pend_v_r <= 1'b1;
        if (pend_v_r) out_v_r <= 1'b1;
      end
      if (state_r == S_FLUSH && pend_v_r && out_free) begin
        pend_v_r <= 1'b0;
        out_v_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pc_r    <= in_pc;
          block_r <= in_addr[ADDR_EFF-1:OFF_BITS];
          scan_r  <= '0;
        end
      end
      S_SCHK: begin
        ent_r  <= tbl_rd_entry;
        eidx_r <= scan_r;
        if (!hit && scan_r != IDX_BITS'(TABLE_ENTRIES - 1)) scan_r <= scan_r + IDX_BITS'(1);
      end
      S_HIT: begin
        head_r   <= new_head;
        fill_r   <= new_fill;
        start_r  <= new_head;
        p_r      <= FILL_BITS'(1);
        i_r      <= '0;
        j_r      <= '0;
        patpos_r <= pos_sub(new_head, FILL_BITS'(1));
        qpos_r   <= pos_sub(new_head, new_fill);
        found_r  <= 1'b0;
      end
      S_SRCH_CMP: begin
        if (srch_more) begin
          if (cmp_eq) begin
            found_r <= 1'b1;
            fpos_r  <= qpos_r;
          end
          i_r    <= i_inc;
          qpos_r <= pos_inc(qpos_r);
          // The pattern index wraps back to the oldest pattern delta every p steps.
          if (j_r + FILL_BITS'(1) == p_r) begin
            j_r      <= '0;
            patpos_r <= pos_sub(head_r, p_r);
          end else begin
            j_r      <= j_r + FILL_BITS'(1);
            patpos_r <= pos_inc(patpos_r);
          end
        end else begin
          if (cmp_eq) start_r <= qpos_r;
          else if (found_r) start_r <= fpos_r;
          p_r      <= p_r + FILL_BITS'(1);
          i_r      <= '0;
          j_r      <= '0;
          patpos_r <= pos_sub(head_r, p_r + FILL_BITS'(1));
          qpos_r   <= pos_sub(head_r, fill_r);
          found_r  <= 1'b0;
        end
      end
      S_REPLAY: begin
        t_r    <= start_r;
        prev_r <= blk_ext;
        drop_r <= 1'b0;
        n_r    <= '0;
      end
      S_FLT_ACC: begin
        drop_r <= drop_r | cmp_eq;
        if (t_last) begin
          t_r    <= start_r;
          prev_r <= blk_ext;
        end else begin
          t_r    <= t_inc;
          prev_r <= add_y;
        end
      end
      S_EMT_ACC: begin
        prev_r      <= add_y;
        t_r         <= t_inc;
        cand_addr_r <= PFA_BITS'(cand_bytes);
      end
      S_EMT_PUSH: begin
        if (push_move) begin
          pend_addr_r <= cand_addr_r;
          n_r         <= n_r + CNT_BITS'(1);
          if (pend_v_r) begin
            out_addr_r <= pend_addr_r;
            out_last_r <= 1'b0;
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_r && out_free) begin
          out_addr_r <= pend_addr_r;
          out_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_v_r;
  assign out_addr  = out_addr_r;
  assign out_last  = out_last_r;

endmodule
